@@ hdl/slc_pkg.sv @@
// Package for the source line classifier: character constants, count width,
// transaction structs and the per-line summary passed from front to back.
// No dependencies.
package slc_pkg;

  // Width of the saturating non-blank line counter
  localparam int unsigned COUNT_WIDTH = 32;
  // Width of the reported count field
  localparam int unsigned REPORT_WIDTH = 32;

  // Character codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;

  // Progress of the search for the leading pair of a line
  typedef enum logic [1:0] {
    LEAD_NONE  = 2'd0,  // only space or tab so far
    LEAD_SLASH = 2'd1,  // first non-blank byte was a slash
    LEAD_DONE  = 2'd2   // leading pair decided
  } lead_phase_t;

  // One byte of source text
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_last;
    logic       file_last;
  } item_t;

  // One line classification
  typedef struct packed {
    logic                    is_blank;
    logic                    is_comment;
    logic                    block_open;
    logic [REPORT_WIDTH-1:0] nonblank_lines;
  } result_t;

  // Line summary handed from the scanner to the block tracker
  typedef struct packed {
    logic any_nonblank;
    logic single;            // single-line comment test passed
    logic open_seen;
    logic close_after_open;
    logic close_seen;
    logic file_end;
  } line_sum_t;

endpackage

@@ hdl/source_line_classifier.sv @@
// Top level of the source line classifier: byte scanner, summary queue and
// block tracker. Depends on slc_pkg, slc_front, slc_fifo and slc_back.
//
// Usage: C source text enters one byte per transaction on the item channel
// (item_valid/item_ready), each byte with line_last and file_last marks.
// The byte carrying either mark closes a line and yields exactly one result
// transaction on the result channel (result_valid/result_ready) with the
// blank and comment flags, the open-block flag and the running non-blank
// line count; other bytes yield nothing. After a file_last byte the block
// state and the count go back to zero.
// Throughput: one byte per cycle while the queue is not full. The scanner
// classifies each byte combinationally and pushes a line summary into a
// two-entry queue; the block tracker pops one summary per cycle, when the
// result register is empty or being read, into that register. A line-end
// byte's summary is queued as it is accepted; the result loads at its pop.
// Reset: synchronous rst clears all line flags, the queue, the block state,
// the count and the result valid.
// Stalls: while result_ready is low the queue fills; bytes keep being taken
// until the queue is full, after which item_ready stays low.
module source_line_classifier (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  slc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output slc_pkg::result_t result
);

  logic               take, push, pop, full, not_empty;
  slc_pkg::line_sum_t push_sum, pop_sum;

  assign item_ready = !full;
  assign take       = item_valid && item_ready;

  slc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .push    (push),
    .summary (push_sum)
  );

  slc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_sum),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .pop_data  (pop_sum)
  );

  slc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (not_empty),
    .summary      (pop_sum),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ hdl/slc_front.sv @@
// Byte scanner: gathers per-line flags and emits one line summary per line end.
// Depends on slc_pkg.
module slc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,      // byte transaction completes this cycle
  input  slc_pkg::item_t     item,
  output logic               push,
  output slc_pkg::line_sum_t summary
);

  slc_pkg::lead_phase_t lead_phase, lead_phase_next;
  logic [7:0] prev_char, prev_prev_char;
  logic       any_nonblank, lead_line_comment, lead_block_open;
  logic       open_seen, close_after_open, close_seen, opener_star_last;

  logic       any_nonblank_next, lead_line_comment_next, lead_block_open_next;
  logic       open_seen_next, close_after_open_next, close_seen_next;
  logic       opener_star_last_next;
  logic       space_or_tab, line_end, close_hit, open_hit, tail_close;

  // Flag updates for the current byte
  always_comb begin
    space_or_tab = (item.char_code == slc_pkg::CH_SP) ||
                   (item.char_code == slc_pkg::CH_TAB);
    line_end     = item.line_last || item.file_last;

    any_nonblank_next = any_nonblank ||
                        (!space_or_tab && item.char_code != slc_pkg::CH_NL);

    lead_phase_next        = lead_phase;
    lead_line_comment_next = lead_line_comment;
    lead_block_open_next   = lead_block_open;
    unique case (lead_phase)
      slc_pkg::LEAD_NONE: begin
        if (!space_or_tab) begin
          lead_phase_next = (item.char_code == slc_pkg::CH_SLASH) ?
                            slc_pkg::LEAD_SLASH : slc_pkg::LEAD_DONE;
        end
      end
      slc_pkg::LEAD_SLASH: begin
        lead_line_comment_next = (item.char_code == slc_pkg::CH_SLASH);
        lead_block_open_next   = (item.char_code == slc_pkg::CH_STAR);
        lead_phase_next        = slc_pkg::LEAD_DONE;
      end
      default: lead_phase_next = slc_pkg::LEAD_DONE;
    endcase

    // close is checked against the opener state before this byte
    close_hit = (prev_char == slc_pkg::CH_STAR) && (item.char_code == slc_pkg::CH_SLASH);
    close_seen_next       = close_seen || close_hit;
    close_after_open_next = close_after_open ||
                            (close_hit && open_seen && !opener_star_last);
    open_hit = (prev_char == slc_pkg::CH_SLASH) && (item.char_code == slc_pkg::CH_STAR) &&
               !open_seen;
    open_seen_next        = open_seen || open_hit;
    opener_star_last_next = open_hit;

    // tail pair, ignoring a final newline
    if (item.char_code == slc_pkg::CH_NL) begin
      tail_close = (prev_prev_char == slc_pkg::CH_STAR) && (prev_char == slc_pkg::CH_SLASH);
    end else begin
      tail_close = (prev_char == slc_pkg::CH_STAR) && (item.char_code == slc_pkg::CH_SLASH);
    end

    push                     = take && line_end;
    summary.any_nonblank     = any_nonblank_next;
    summary.single           = lead_line_comment_next ||
                               (lead_block_open_next && close_after_open_next && tail_close);
    summary.open_seen        = open_seen_next;
    summary.close_after_open = close_after_open_next;
    summary.close_seen       = close_seen_next;
    summary.file_end         = item.file_last;
  end

  // Lead-phase state register
  always_ff @(posedge clk) begin
    if (rst || push) begin
      lead_phase <= slc_pkg::LEAD_NONE;
    end else if (take) begin
      lead_phase <= lead_phase_next;
    end
  end

  // Line flag registers, cleared at each line end
  always_ff @(posedge clk) begin
    if (rst || push) begin
      prev_char         <= '0;
      prev_prev_char    <= '0;
      any_nonblank      <= 1'b0;
      lead_line_comment <= 1'b0;
      lead_block_open   <= 1'b0;
      open_seen         <= 1'b0;
      close_after_open  <= 1'b0;
      close_seen        <= 1'b0;
      opener_star_last  <= 1'b0;
    end else if (take) begin
      prev_prev_char    <= prev_char;
      prev_char         <= item.char_code;
      any_nonblank      <= any_nonblank_next;
      lead_line_comment <= lead_line_comment_next;
      lead_block_open   <= lead_block_open_next;
      open_seen         <= open_seen_next;
      close_after_open  <= close_after_open_next;
      close_seen        <= close_seen_next;
      opener_star_last  <= opener_star_last_next;
    end
  end

`ifndef NO_ASSERTIONS
  // an opener's star cannot be flagged without the opener itself
  a_star_needs_open: assert property (@(posedge clk) disable iff (rst)
    opener_star_last |-> open_seen)
    else $error("opener star flag set without opener");
  // a close after the opener implies a close was seen
  a_cao_implies_close: assert property (@(posedge clk) disable iff (rst)
    close_after_open |-> (close_seen && open_seen))
    else $error("close-after-open without close or opener");
  // leading pair flags are exclusive and only set once decided
  a_lead_flags: assert property (@(posedge clk) disable iff (rst)
    (lead_line_comment || lead_block_open) |->
      (lead_phase == slc_pkg::LEAD_DONE && !(lead_line_comment && lead_block_open)))
    else $error("leading pair flags inconsistent");
`endif

endmodule

@@ hdl/slc_fifo.sv @@
// Two-entry queue of line summaries between the scanner and the block tracker.
// Depends on slc_pkg.
module slc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  slc_pkg::line_sum_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output slc_pkg::line_sum_t pop_data
);

  slc_pkg::line_sum_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("summary queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("summary queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("summary queue fill out of range");
`endif

endmodule

@@ hdl/slc_back.sv @@
// Block tracker: applies the comment rules to each line summary, keeps the
// open-block state and the saturating count, and holds the result register.
// Depends on slc_pkg.
module slc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               sum_valid,
  input  slc_pkg::line_sum_t summary,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output slc_pkg::result_t   result
);

  logic                            in_block, in_block_next;
  logic [slc_pkg::COUNT_WIDTH-1:0] nonblank_count, count_next;
  logic                            comment;

  // Classification of the popped line
  always_comb begin
    pop           = sum_valid && (!result_valid || result_ready);
    in_block_next = in_block;
    if (summary.single) begin
      comment = 1'b1;
    end else if (in_block) begin
      comment = 1'b1;
      if (summary.close_seen) in_block_next = 1'b0;
    end else if (summary.open_seen && !summary.close_after_open) begin
      comment       = 1'b1;
      in_block_next = 1'b1;
    end else begin
      comment = 1'b0;
    end
    count_next = nonblank_count;
    if (summary.any_nonblank && nonblank_count != '1) begin
      count_next = nonblank_count + slc_pkg::COUNT_WIDTH'(1);
    end
  end

  // File state, cleared after a file end
  always_ff @(posedge clk) begin
    if (rst) begin
      in_block       <= 1'b0;
      nonblank_count <= '0;
    end else if (pop) begin
      in_block       <= summary.file_end ? 1'b0 : in_block_next;
      nonblank_count <= summary.file_end ? '0 : count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.is_blank       <= !summary.any_nonblank;
      result.is_comment     <= comment;
      result.block_open     <= in_block_next;
      result.nonblank_lines <= slc_pkg::REPORT_WIDTH'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_file_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && summary.file_end) |=> (nonblank_count == '0 && !in_block))
    else $error("file state not cleared at file end");
  a_blank_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !summary.any_nonblank && !summary.file_end) |=>
      (nonblank_count == $past(nonblank_count)))
    else $error("blank line changed the count");
  a_open_is_comment: assert property (@(posedge clk) disable iff (rst)
    (pop && in_block_next) |=> result.is_comment)
    else $error("line with open block not marked as comment");
`endif

endmodule
